>>> src/eupi_pkg.sv
`default_nettype none

package eupi_pkg;

   // Field widths
   localparam int ENC_W      = 13;
   localparam int STICK_W    = 11;
   localparam int RATE_W     = 16;
   localparam int GAIN_W     = 16;
   localparam int LIM_W      = 16;
   localparam int SCALE_W    = 8;
   localparam int SPEED_W    = 17;
   localparam int COUNT_W    = 32;

   // Datapath widths: err fits 19 bits, products of a 16-bit gain stay within 36
   localparam int ERR_W      = 19;
   localparam int PROD_W     = 36;
   localparam int DPROD_W    = 33;
   localparam int SUM_W      = 38;
   localparam int FRAC_W     = 8;
   localparam int SAT_W      = LIM_W + FRAC_W + 1;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Encoder geometry
   localparam int ENC_COUNTS = 8192;
   localparam int ENC_HALF   = ENC_COUNTS / 2;
   localparam logic signed [COUNT_W-1:0] ENC_COUNTS_S = COUNT_W'(ENC_COUNTS);
   localparam logic signed [COUNT_W-1:0] ENC_HALF_S   = COUNT_W'(ENC_HALF);

   // Bias for truncation toward zero of a negative Q.8 value
   localparam logic signed [SAT_W-1:0] ROUND_BIAS = SAT_W'((2 ** FRAC_W) - 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PROP_GAIN   = 3'd0,
      CSR_INTEG_GAIN  = 3'd1,
      CSR_DERIV_GAIN  = 3'd2,
      CSR_INTEG_LIMIT = 3'd3,
      CSR_OUT_LIMIT   = 3'd4,
      CSR_STICK_SCALE = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [GAIN_W-1:0]  prop_gain;
      logic [GAIN_W-1:0]  integ_gain;
      logic [GAIN_W-1:0]  deriv_gain;
      logic [LIM_W-1:0]   integ_limit;
      logic [LIM_W-1:0]   out_limit;
      logic [SCALE_W-1:0] stick_scale;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      prop_gain:   GAIN_W'(256),
      integ_gain:  GAIN_W'(0),
      deriv_gain:  GAIN_W'(0),
      integ_limit: LIM_W'(8192),
      out_limit:   LIM_W'(16384),
      stick_scale: SCALE_W'(10)
   };

   // Stage advance strobes, one per pipeline stage after the input register
   typedef struct packed {
      logic go_b;
      logic go_c;
      logic go_d;
      logic go_e;
   } pipe_ctl_type;

   // Symmetric clamp of a Q.8 value to +/- lim (lim in integer units)
   function automatic logic signed [SAT_W-1:0] clamp_sym(
      input logic signed [SUM_W-1:0] v,
      input logic [LIM_W-1:0]        lim
   );
      logic signed [SUM_W-1:0] hi;
      logic signed [SUM_W-1:0] lo;
      logic signed [SUM_W-1:0] res;
      hi = $signed({{(SUM_W-LIM_W-FRAC_W){1'b0}}, lim, {FRAC_W{1'b0}}});
      lo = -hi;
      if (v > hi) begin
         res = hi;
      end else if (v < lo) begin
         res = lo;
      end else begin
         res = v;
      end
      return res[SAT_W-1:0];
   endfunction

endpackage

`default_nettype wire

>>> src/eupi_channels.sv
`default_nettype none

// Request channel: one control tick
interface eupi_req_if;
   logic                                   valid;
   logic                                   ready;
   logic        [eupi_pkg::ENC_W-1:0]      encoder_pos;
   logic signed [eupi_pkg::STICK_W-1:0]    stick_value;
   logic signed [eupi_pkg::RATE_W-1:0]     rate_term;

   modport source (output valid, encoder_pos, stick_value, rate_term, input ready);
   modport sink   (input valid, encoder_pos, stick_value, rate_term, output ready);
endinterface

// Response channel: speed setpoint and multi-turn count
interface eupi_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [eupi_pkg::SPEED_W-1:0]    speed_setpoint;
   logic signed [eupi_pkg::COUNT_W-1:0]    turn_count;

   modport source (output valid, speed_setpoint, turn_count, input ready);
   modport sink   (input valid, speed_setpoint, turn_count, output ready);
endinterface

`default_nettype wire

>>> src/eupi_csr.sv
`default_nettype none

module eupi_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_we,
   input  wire logic [eupi_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [eupi_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output eupi_pkg::cfg_type                      cfg
);

   eupi_pkg::cfg_type cfg_ff;
   eupi_pkg::cfg_type cfg_in;

   // Register write decode; unknown indexes leave everything as it is
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (eupi_pkg::csr_index_type'(csr_index))
            eupi_pkg::CSR_PROP_GAIN:   cfg_in.prop_gain   = csr_wdata;
            eupi_pkg::CSR_INTEG_GAIN:  cfg_in.integ_gain  = csr_wdata;
            eupi_pkg::CSR_DERIV_GAIN:  cfg_in.deriv_gain  = csr_wdata;
            eupi_pkg::CSR_INTEG_LIMIT: cfg_in.integ_limit = csr_wdata;
            eupi_pkg::CSR_OUT_LIMIT:   cfg_in.out_limit   = csr_wdata;
            eupi_pkg::CSR_STICK_SCALE: cfg_in.stick_scale = csr_wdata[eupi_pkg::SCALE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= eupi_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

>>> src/eupi_unwrap.sv
`default_nettype none

module eupi_unwrap (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                go,
   input  wire logic        [eupi_pkg::ENC_W-1:0]   encoder_pos,
   output logic signed      [eupi_pkg::COUNT_W-1:0] turn_count
);

   logic        [eupi_pkg::ENC_W-1:0]   last_ff;
   logic                                primed_ff;
   logic signed [eupi_pkg::COUNT_W-1:0] accum_ff;
   logic signed [eupi_pkg::COUNT_W-1:0] accum_in;
   logic signed [eupi_pkg::COUNT_W-1:0] diff;
   logic signed [eupi_pkg::COUNT_W-1:0] delta;

   // Step between readings, folded across the wrap; exactly half a turn counts as no move
   always_comb begin
      diff = $signed({{(eupi_pkg::COUNT_W-eupi_pkg::ENC_W){1'b0}}, encoder_pos})
           - $signed({{(eupi_pkg::COUNT_W-eupi_pkg::ENC_W){1'b0}}, last_ff});
      if (diff > eupi_pkg::ENC_HALF_S) begin
         delta = diff - eupi_pkg::ENC_COUNTS_S;
      end else if (diff == eupi_pkg::ENC_HALF_S) begin
         delta = '0;
      end else if (diff < -eupi_pkg::ENC_HALF_S) begin
         delta = diff + eupi_pkg::ENC_COUNTS_S;
      end else if (diff == -eupi_pkg::ENC_HALF_S) begin
         delta = '0;
      end else begin
         delta = diff;
      end
      // first reading after reset only primes the tracker
      accum_in = primed_ff ? (accum_ff + delta) : accum_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff   <= '0;
         primed_ff <= 1'b0;
         accum_ff  <= '0;
      end else if (go) begin
         last_ff   <= encoder_pos;
         primed_ff <= 1'b1;
         accum_ff  <= accum_in;
      end
   end

   assign turn_count = accum_ff;

endmodule

`default_nettype wire

>>> src/eupi_pid.sv
`default_nettype none

module eupi_pid (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire eupi_pkg::pipe_ctl_type              ctl,
   input  wire eupi_pkg::cfg_type                   cfg,
   input  wire logic signed [eupi_pkg::STICK_W-1:0] stick_value,
   input  wire logic signed [eupi_pkg::RATE_W-1:0]  rate_term,
   input  wire logic signed [eupi_pkg::COUNT_W-1:0] turn_count_b,
   output logic signed      [eupi_pkg::SPEED_W-1:0] speed_setpoint,
   output logic signed      [eupi_pkg::COUNT_W-1:0] turn_count
);

   // stage b
   logic signed [eupi_pkg::ERR_W:0]     err_full;
   logic signed [eupi_pkg::ERR_W-1:0]   err_in;
   logic signed [eupi_pkg::ERR_W-1:0]   err_ff;
   logic signed [eupi_pkg::RATE_W-1:0]  rate_ff;
   // stage c
   logic signed [eupi_pkg::PROD_W-1:0]  p_in;
   logic signed [eupi_pkg::PROD_W-1:0]  p_ff;
   logic signed [eupi_pkg::PROD_W-1:0]  ip_in;
   logic signed [eupi_pkg::PROD_W-1:0]  ip_ff;
   logic signed [eupi_pkg::DPROD_W-1:0] d_in;
   logic signed [eupi_pkg::DPROD_W-1:0] d_ff;
   logic signed [eupi_pkg::COUNT_W-1:0] tc_c_ff;
   // stage d
   logic signed [eupi_pkg::SUM_W-1:0]   pd_in;
   logic signed [eupi_pkg::SUM_W-1:0]   pd_ff;
   logic signed [eupi_pkg::SAT_W-1:0]   acc_in;
   logic signed [eupi_pkg::SAT_W-1:0]   acc_ff;
   logic signed [eupi_pkg::COUNT_W-1:0] tc_d_ff;
   // stage e
   logic signed [eupi_pkg::SUM_W-1:0]   total;
   logic signed [eupi_pkg::SAT_W-1:0]   sat;
   logic signed [eupi_pkg::SAT_W-1:0]   biased;
   logic signed [eupi_pkg::SPEED_W-1:0] speed_in;
   logic signed [eupi_pkg::SPEED_W-1:0] speed_ff;
   logic signed [eupi_pkg::COUNT_W-1:0] tc_e_ff;

   // Position error in counts
   assign err_full = stick_value * $signed({1'b0, cfg.stick_scale});
   assign err_in   = err_full[eupi_pkg::ERR_W-1:0];

   always_ff @(posedge clock) begin
      if (ctl.go_b) begin
         err_ff  <= err_in;
         rate_ff <= rate_term;
      end
   end

   // Gain products, each registered
   assign p_in  = $signed({1'b0, cfg.prop_gain}) * err_ff;
   assign ip_in = $signed({1'b0, cfg.integ_gain}) * err_ff;
   assign d_in  = $signed({1'b0, cfg.deriv_gain}) * rate_ff;

   always_ff @(posedge clock) begin
      if (ctl.go_c) begin
         p_ff    <= p_in;
         ip_ff   <= ip_in;
         d_ff    <= d_in;
         tc_c_ff <= turn_count_b;
      end
   end

   // Integrator update with clamp; P and D summed alongside
   assign acc_in = eupi_pkg::clamp_sym(eupi_pkg::SUM_W'(acc_ff) + eupi_pkg::SUM_W'(ip_ff),
                                       cfg.integ_limit);
   assign pd_in  = eupi_pkg::SUM_W'(p_ff) + eupi_pkg::SUM_W'(d_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (ctl.go_d) begin
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.go_d) begin
         pd_ff   <= pd_in;
         tc_d_ff <= tc_c_ff;
      end
   end

   // Output saturation, then Q.8 to integer truncating toward zero
   assign total    = pd_ff + eupi_pkg::SUM_W'(acc_ff);
   assign sat      = eupi_pkg::clamp_sym(total, cfg.out_limit);
   assign biased   = sat + (sat[eupi_pkg::SAT_W-1] ? eupi_pkg::ROUND_BIAS : '0);
   assign speed_in = biased[eupi_pkg::SAT_W-1:eupi_pkg::FRAC_W];

   always_ff @(posedge clock) begin
      if (ctl.go_e) begin
         speed_ff <= speed_in;
         tc_e_ff  <= tc_d_ff;
      end
   end

   assign speed_setpoint = speed_ff;
   assign turn_count     = tc_e_ff;

endmodule

`default_nettype wire

>>> src/encoder_unwrap_position_pi.sv
// Multi-turn encoder tracker with a positional PI(D) angle loop.
// Requests arrive on req_chan (valid/ready): a 13-bit encoder reading, the
// stick value and an external rate term. Each request gives exactly one
// response on rsp_chan (valid/ready): the saturated speed setpoint and the
// multi-turn count after this request's unwrap.
// Gains, limits and stick scale are written on the csr_ port (write enable,
// index, data); the user must write them only while no request is in
// flight; the block does not enforce this. Five-stage pipeline (a to e);
// one request per cycle while rsp_chan is ready, bounded by the integrator
// add-and-clamp feedback, which closes in a single stage.
// Reset (synchronous) loads the register defaults, clears the count, the
// integrator and all pipeline valids; the first request after reset only
// primes the encoder tracker but still produces a response.
// When rsp_chan stalls, the response is held in the output register, empty
// stages ahead of it keep filling and req_chan.ready drops only once every
// stage holds a request.
`default_nettype none

module encoder_unwrap_position_pi (
   input  wire logic                              clock,
   input  wire logic                              reset,
   eupi_req_if.sink                               req_chan,
   eupi_rsp_if.source                             rsp_chan,
   input  wire logic                              csr_we,
   input  wire logic [eupi_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [eupi_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   eupi_pkg::cfg_type                   cfg;
   eupi_pkg::pipe_ctl_type              ctl;

   logic a_valid_ff, b_valid_ff, c_valid_ff, d_valid_ff, e_valid_ff;
   logic a_valid_in, b_valid_in, c_valid_in, d_valid_in, e_valid_in;
   logic free_a, free_b, free_c, free_d, free_e;
   logic take;

   logic        [eupi_pkg::ENC_W-1:0]   enc_ff;
   logic signed [eupi_pkg::STICK_W-1:0] stick_ff;
   logic signed [eupi_pkg::RATE_W-1:0]  rate_ff;
   logic signed [eupi_pkg::COUNT_W-1:0] turn_count_b;

   // Stage advance: a stage moves on when the next one is empty or moving too
   always_comb begin
      free_e     = !e_valid_ff || rsp_chan.ready;
      ctl.go_e   = d_valid_ff && free_e;
      free_d     = !d_valid_ff || ctl.go_e;
      ctl.go_d   = c_valid_ff && free_d;
      free_c     = !c_valid_ff || ctl.go_d;
      ctl.go_c   = b_valid_ff && free_c;
      free_b     = !b_valid_ff || ctl.go_c;
      ctl.go_b   = a_valid_ff && free_b;
      free_a     = !a_valid_ff || ctl.go_b;
      take       = req_chan.valid && free_a;

      a_valid_in = take     || (a_valid_ff && !ctl.go_b);
      b_valid_in = ctl.go_b || (b_valid_ff && !ctl.go_c);
      c_valid_in = ctl.go_c || (c_valid_ff && !ctl.go_d);
      d_valid_in = ctl.go_d || (d_valid_ff && !ctl.go_e);
      e_valid_in = ctl.go_e || (e_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         c_valid_ff <= c_valid_in;
         d_valid_ff <= d_valid_in;
         e_valid_ff <= e_valid_in;
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (take) begin
         enc_ff   <= req_chan.encoder_pos;
         stick_ff <= req_chan.stick_value;
         rate_ff  <= req_chan.rate_term;
      end
   end

   eupi_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   eupi_unwrap u_unwrap (
      .clock       (clock),
      .reset       (reset),
      .go          (ctl.go_b),
      .encoder_pos (enc_ff),
      .turn_count  (turn_count_b)
   );

   eupi_pid u_pid (
      .clock          (clock),
      .reset          (reset),
      .ctl            (ctl),
      .cfg            (cfg),
      .stick_value    (stick_ff),
      .rate_term      (rate_ff),
      .turn_count_b   (turn_count_b),
      .speed_setpoint (rsp_chan.speed_setpoint),
      .turn_count     (rsp_chan.turn_count)
   );

   assign req_chan.ready = free_a;
   assign rsp_chan.valid = e_valid_ff;

endmodule

`default_nettype wire
